>>> hdl/serial_mouse_report_responder_macros.svh
// Assertion macros shared by the responder. The enclosing module must have
// clk and rst in scope.
`ifndef SERIAL_MOUSE_REPORT_RESPONDER_MACROS_SVH
`define SERIAL_MOUSE_REPORT_RESPONDER_MACROS_SVH

// Consequent holds in the same cycle as the antecedent.
`define SMRR_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define SMRR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/smrr_pkg.sv
`default_nettype none

package smrr_pkg;

  typedef enum logic [1:0] {
    OP_BYTE   = 2'd0,
    OP_BUTTON = 2'd1,
    OP_RESET  = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_READY  = 3'd1,
    PH_ID_HI  = 3'd2,
    PH_BTN_LO = 3'd3,
    PH_BTN_HI = 3'd4,
    PH_DX     = 3'd5,
    PH_DY     = 3'd6
  } phase_t;

  localparam logic [15:0] DEVICE_ID   = 16'h5A12;
  localparam logic [7:0]  CMD_POLL    = 8'h01;
  localparam logic [7:0]  CMD_READ    = 8'h42;
  localparam logic [7:0]  IDLE_BYTE   = 8'hFF;
  localparam logic [3:0]  LEFT_BIT    = 4'd11;
  localparam logic [3:0]  RIGHT_BIT   = 4'd10;
  localparam logic [15:0] BUTTONS_OFF = 16'hFFFF;

  typedef struct packed {
    logic [1:0]         op;
    logic [7:0]         host_byte;
    logic signed [15:0] host_x;
    logic signed [15:0] host_y;
    logic [1:0]         button_index;
    logic               pressed;
  } item_t;

  typedef struct packed {
    logic [7:0] reply_byte;
    logic       ack;
  } reply_t;

  // Difference of two 16-bit positions, saturated to a signed byte.
  function automatic logic [7:0] clamp_delta(input logic [15:0] now,
                                             input logic [15:0] last);
    logic [16:0] d;
    begin
      d = {now[15], now} - {last[15], last};
      if (d[16:7] == 10'h000 || d[16:7] == 10'h3FF) begin
        clamp_delta = d[7:0];
      end else if (d[16]) begin
        clamp_delta = 8'h80;
      end else begin
        clamp_delta = 8'h7F;
      end
    end
  endfunction

endpackage

`default_nettype wire

>>> hdl/smrr_in_reg.sv
`default_nettype none

// Input register stage: captures one request and holds it until the core
// passes it on.
module smrr_in_reg (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire smrr_pkg::item_t in_item,
  output logic                s1_valid,
  output smrr_pkg::item_t     s1_item,
  input  wire logic           s1_take
);

  logic s1_valid_next;

  assign in_stall = s1_valid && !s1_take;

  always_comb begin
    if (in_valid && !in_stall) begin
      s1_valid_next = 1'b1;
    end else if (s1_take) begin
      s1_valid_next = 1'b0;
    end else begin
      s1_valid_next = s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= s1_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_item <= in_item;
    end
  end

endmodule

`default_nettype wire

>>> hdl/smrr_core.sv
`default_nettype none

// Transfer sequencer, button word and pointer tracking. The reply is pure
// logic on the registered request; state moves on when the request is taken.
module smrr_core (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire smrr_pkg::item_t s1_item,
  input  wire logic            fire,
  output smrr_pkg::reply_t     reply
);

  smrr_pkg::phase_t phase;
  smrr_pkg::phase_t phase_next;
  logic [15:0] button_word;
  logic [15:0] button_word_next;
  logic [15:0] last_x;
  logic [15:0] last_y;
  logic [7:0]  motion_y;
  logic [7:0]  motion_x_new;
  logic [7:0]  motion_y_new;
  logic        sample;
  logic [3:0]  bit_pos;

  assign motion_x_new = smrr_pkg::clamp_delta(s1_item.host_x, last_x);
  assign motion_y_new = smrr_pkg::clamp_delta(s1_item.host_y, last_y);
  assign sample = (s1_item.op == smrr_pkg::OP_BYTE) && (phase == smrr_pkg::PH_DX);
  assign bit_pos = (s1_item.button_index == 2'd0) ? smrr_pkg::LEFT_BIT
                                                  : smrr_pkg::RIGHT_BIT;

  // Next phase.
  always_comb begin
    phase_next = phase;
    unique case (s1_item.op)
      smrr_pkg::OP_BYTE: begin
        unique case (phase)
          smrr_pkg::PH_IDLE: begin
            if (s1_item.host_byte == smrr_pkg::CMD_POLL) begin
              phase_next = smrr_pkg::PH_READY;
            end
          end
          smrr_pkg::PH_READY: begin
            if (s1_item.host_byte == smrr_pkg::CMD_READ) begin
              phase_next = smrr_pkg::PH_ID_HI;
            end
          end
          smrr_pkg::PH_ID_HI:  phase_next = smrr_pkg::PH_BTN_LO;
          smrr_pkg::PH_BTN_LO: phase_next = smrr_pkg::PH_BTN_HI;
          smrr_pkg::PH_BTN_HI: phase_next = smrr_pkg::PH_DX;
          smrr_pkg::PH_DX:     phase_next = smrr_pkg::PH_DY;
          default:             phase_next = smrr_pkg::PH_IDLE;
        endcase
      end
      smrr_pkg::OP_RESET: phase_next = smrr_pkg::PH_IDLE;
      default:            phase_next = phase;
    endcase
  end

  // Reply byte and acknowledge.
  always_comb begin
    reply.reply_byte = smrr_pkg::IDLE_BYTE;
    reply.ack        = 1'b0;
    if (s1_item.op == smrr_pkg::OP_BYTE) begin
      unique case (phase)
        smrr_pkg::PH_IDLE: begin
          reply.ack = (s1_item.host_byte == smrr_pkg::CMD_POLL);
        end
        smrr_pkg::PH_READY: begin
          if (s1_item.host_byte == smrr_pkg::CMD_READ) begin
            reply.reply_byte = smrr_pkg::DEVICE_ID[7:0];
            reply.ack        = 1'b1;
          end
        end
        smrr_pkg::PH_ID_HI: begin
          reply.reply_byte = smrr_pkg::DEVICE_ID[15:8];
          reply.ack        = 1'b1;
        end
        smrr_pkg::PH_BTN_LO: begin
          reply.reply_byte = button_word[7:0];
          reply.ack        = 1'b1;
        end
        smrr_pkg::PH_BTN_HI: begin
          reply.reply_byte = button_word[15:8];
          reply.ack        = 1'b1;
        end
        smrr_pkg::PH_DX: begin
          reply.reply_byte = motion_x_new;
          reply.ack        = 1'b1;
        end
        smrr_pkg::PH_DY: begin
          reply.reply_byte = motion_y;
        end
        default: begin
          reply.reply_byte = smrr_pkg::IDLE_BYTE;
        end
      endcase
    end
  end

  // Button events; indices above right are dropped.
  always_comb begin
    button_word_next = button_word;
    if (s1_item.op == smrr_pkg::OP_BUTTON && !s1_item.button_index[1]) begin
      button_word_next[bit_pos] = !s1_item.pressed;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= smrr_pkg::PH_IDLE;
      button_word <= smrr_pkg::BUTTONS_OFF;
      last_x      <= 16'h0000;
      last_y      <= 16'h0000;
      motion_y    <= 8'h00;
    end else if (fire) begin
      phase       <= phase_next;
      button_word <= button_word_next;
      if (sample) begin
        last_x   <= s1_item.host_x;
        last_y   <= s1_item.host_y;
        motion_y <= motion_y_new;
      end
    end
  end

endmodule

`default_nettype wire

>>> hdl/smrr_out_reg.sv
`default_nettype none

// Result register: holds one reply until the receiver takes it, and accepts
// the next one in the same cycle the current one leaves.
module smrr_out_reg (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             load_valid,
  output logic                  load_ready,
  input  wire smrr_pkg::reply_t load_reply,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic [7:0]            reply_byte,
  output logic                  ack
);

  assign load_ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_ready) begin
      out_valid <= load_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load_valid && load_ready) begin
      reply_byte <= load_reply.reply_byte;
      ack        <= load_reply.ack;
    end
  end

endmodule

`default_nettype wire

>>> hdl/serial_mouse_report_responder.sv
// A request goes into the input register, then its reply into the output register.
// Throughput: one request per cycle while the receiver does not stall, set by the input
// register, the combinational sequencer logic and the output register, which add no bubbles.
// Reset (rst, synchronous, active high): sequencer idle, no buttons pressed,
// last pointer position and motion deltas zero, both stages empty.
`default_nettype none

`include "serial_mouse_report_responder_macros.svh"

module serial_mouse_report_responder (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         op,
  input  wire logic [7:0]         host_byte,
  input  wire logic signed [15:0] host_x,
  input  wire logic signed [15:0] host_y,
  input  wire logic [1:0]         button_index,
  input  wire logic               pressed,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [7:0]              reply_byte,
  output logic                    ack
);

  // Gather the request fields into one word for the input register.
  smrr_pkg::item_t  in_item;
  smrr_pkg::item_t  s1_item;
  smrr_pkg::reply_t reply;
  logic             s1_valid;
  logic             load_ready;
  logic             fire;

  assign in_item.op           = op;
  assign in_item.host_byte    = host_byte;
  assign in_item.host_x       = host_x;
  assign in_item.host_y       = host_y;
  assign in_item.button_index = button_index;
  assign in_item.pressed      = pressed;

  // A request leaves the input register, and the state is updated, in the
  // same cycle as its reply is written into the output register.
  assign fire = s1_valid && load_ready;

  smrr_in_reg u_in_reg (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .s1_valid (s1_valid),
    .s1_item  (s1_item),
    .s1_take  (fire)
  );

  // The sequencer works on the registered request only; its reply is
  // ready within the cycle.
  smrr_core u_core (
    .clk     (clk),
    .rst     (rst),
    .s1_item (s1_item),
    .fire    (fire),
    .reply   (reply)
  );

  // The output register frees itself as its result is taken, so a stalled
  // receiver only holds the pipe while a result is actually waiting.
  smrr_out_reg u_out_reg (
    .clk        (clk),
    .rst        (rst),
    .load_valid (s1_valid),
    .load_ready (load_ready),
    .load_reply (reply),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .reply_byte (reply_byte),
    .ack        (ack)
  );

  // The input side may only be held back while a result waits downstream.
  `SMRR_ASSERT_SAME(a_stall_cause, in_stall, s1_valid && out_valid && out_stall, "input stalled without a waiting result")
  // A result cannot appear from an empty pipe.
  `SMRR_ASSERT_NEXT(a_no_invented, !out_valid && !s1_valid, !out_valid, "result appeared with no request")
  // Button events, sequencer resets and unused codes never acknowledge.
  `SMRR_ASSERT_NEXT(a_no_ack_non_byte, fire && s1_item.op != smrr_pkg::OP_BYTE, !ack, "acknowledge on a non-exchange request")

endmodule

`default_nettype wire

>>> dv/serial_mouse_report_checker.sv
`timescale 1ns / 100ps

module serial_mouse_report_checker (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  input  wire logic               in_stall,
  input  wire logic [1:0]         op,
  input  wire logic [7:0]         host_byte,
  input  wire logic signed [15:0] host_x,
  input  wire logic signed [15:0] host_y,
  input  wire logic [1:0]         button_index,
  input  wire logic               pressed,
  input  wire logic               out_valid,
  input  wire logic               out_stall,
  input  wire logic [7:0]         reply_byte,
  input  wire logic               ack,
  output int                      errors,
  output int                      pending
);

  localparam logic [1:0] IDX_LEFT  = 2'd0;
  localparam logic [1:0] IDX_RIGHT = 2'd1;

  smrr_pkg::reply_t   awaited_replies[$];
  smrr_pkg::phase_t   seq_phase;
  logic [15:0]        buttons;
  logic signed [15:0] prev_x;
  logic signed [15:0] prev_y;
  logic [7:0]         motion_x;
  logic [7:0]         motion_y;
  int                 mismatch_count = 0;
  int                 outstanding = 0;

  assign errors  = mismatch_count;
  assign pending = outstanding;

  // Pointer movement since the last report, saturated to a signed byte.
  function automatic logic [7:0] saturated_motion(input logic signed [15:0] now,
                                                  input logic signed [15:0] last);
    int diff;
    diff = int'(now) - int'(last);
    if (diff < -128) diff = -128;
    else if (diff > 127) diff = 127;
    return diff[7:0];
  endfunction

  // Works out the reply to one request and moves the mouse state on.
  task automatic predict_reply(input smrr_pkg::item_t req, output smrr_pkg::reply_t rep);
    logic [15:0] mask;
    rep.reply_byte = smrr_pkg::IDLE_BYTE;
    rep.ack        = 1'b0;
    mask           = '0;
    case (req.op)
      smrr_pkg::OP_BYTE: begin
        case (seq_phase)
          smrr_pkg::PH_IDLE: begin
            if (req.host_byte == smrr_pkg::CMD_POLL) begin
              rep.ack   = 1'b1;
              seq_phase = smrr_pkg::PH_READY;
            end
          end
          smrr_pkg::PH_READY: begin
            if (req.host_byte == smrr_pkg::CMD_READ) begin
              rep.reply_byte = smrr_pkg::DEVICE_ID[7:0];
              rep.ack        = 1'b1;
              seq_phase      = smrr_pkg::PH_ID_HI;
            end
          end
          smrr_pkg::PH_ID_HI: begin
            rep.reply_byte = smrr_pkg::DEVICE_ID[15:8];
            rep.ack        = 1'b1;
            seq_phase      = smrr_pkg::PH_BTN_LO;
          end
          smrr_pkg::PH_BTN_LO: begin
            rep.reply_byte = buttons[7:0];
            rep.ack        = 1'b1;
            seq_phase      = smrr_pkg::PH_BTN_HI;
          end
          smrr_pkg::PH_BTN_HI: begin
            rep.reply_byte = buttons[15:8];
            rep.ack        = 1'b1;
            seq_phase      = smrr_pkg::PH_DX;
          end
          smrr_pkg::PH_DX: begin
            motion_x       = saturated_motion(req.host_x, prev_x);
            motion_y       = saturated_motion(req.host_y, prev_y);
            prev_x         = req.host_x;
            prev_y         = req.host_y;
            rep.reply_byte = motion_x;
            rep.ack        = 1'b1;
            seq_phase      = smrr_pkg::PH_DY;
          end
          smrr_pkg::PH_DY: begin
            rep.reply_byte = motion_y;
            seq_phase      = smrr_pkg::PH_IDLE;
          end
          default: begin
            seq_phase = smrr_pkg::PH_IDLE;
          end
        endcase
      end
      smrr_pkg::OP_BUTTON: begin
        if (req.button_index == IDX_LEFT) mask[smrr_pkg::LEFT_BIT] = 1'b1;
        else if (req.button_index == IDX_RIGHT) mask[smrr_pkg::RIGHT_BIT] = 1'b1;
        buttons = req.pressed ? (buttons & ~mask) : (buttons | mask);
      end
      smrr_pkg::OP_RESET: begin
        seq_phase = smrr_pkg::PH_IDLE;
      end
      default: begin
      end
    endcase
  endtask

  always @(posedge clk) begin
    smrr_pkg::item_t  req;
    smrr_pkg::reply_t want;
    if (rst) begin
      seq_phase = smrr_pkg::PH_IDLE;
      buttons   = smrr_pkg::BUTTONS_OFF;
      prev_x    = '0;
      prev_y    = '0;
      motion_x  = '0;
      motion_y  = '0;
      awaited_replies.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (awaited_replies.size() == 0) begin
          mismatch_count++;
          $error("Reply with no request waiting: reply_byte %02h, ack %0b", reply_byte, ack);
        end else begin
          want = awaited_replies.pop_front();
          if (reply_byte !== want.reply_byte) begin
            mismatch_count++;
            $error("reply_byte: expected %02h, actual %02h", want.reply_byte, reply_byte);
          end
          if (ack !== want.ack) begin
            mismatch_count++;
            $error("ack: expected %0b, actual %0b", want.ack, ack);
          end
        end
      end
      if (in_valid && !in_stall) begin
        req = {op, host_byte, host_x, host_y, button_index, pressed};
        predict_reply(req, want);
        awaited_replies.push_back(want);
      end
    end
    outstanding = awaited_replies.size();
  end

endmodule

>>> dv/serial_mouse_report_responder_test.sv
`timescale 1ns / 100ps

// Stimulus and verdict for the serial mouse responder. The checker beside the
// block watches both channels, predicts every reply and counts mismatches;
// this module only makes requests, shapes the idling of both sides and
// decides the outcome at the end of the run.
module serial_mouse_report_responder_test;

  // The one op code that the package leaves without a name; the block must
  // treat it as a request that changes nothing.
  localparam logic [1:0] OP_SPARE = 2'd3;

  // The block holds a request in its input and output registers, so a short drain is plenty.
  localparam int DRAIN_CYCLES    = 10;
  localparam int HOLD_OFF_CYCLES = 300;
  // This limit leaves a wide margin over all phases of the run put together.
  localparam int CYCLE_LIMIT     = 200000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic [1:0]         op = '0;
  logic [7:0]         host_byte = '0;
  logic signed [15:0] host_x = '0;
  logic signed [15:0] host_y = '0;
  logic [1:0]         button_index = '0;
  logic               pressed = 1'b0;
  logic               out_stall = 1'b0;
  wire logic          in_stall;
  wire logic          out_valid;
  wire logic [7:0]    reply_byte;
  wire logic          ack;
  int                 errors;
  int                 pending;

  // Idling of both sides, changed only between phases of the run.
  int                 gap_pct = 0;
  int                 stall_pct = 0;
  int                 hold_requests = 0;
  int                 requests_sent = 0;
  int                 cycle_count = 0;

  // Host pointer position that the random transfers wander around.
  logic signed [15:0] ptr_x = '0;
  logic signed [15:0] ptr_y = '0;

  serial_mouse_report_responder u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .op           (op),
    .host_byte    (host_byte),
    .host_x       (host_x),
    .host_y       (host_y),
    .button_index (button_index),
    .pressed      (pressed),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .reply_byte   (reply_byte),
    .ack          (ack)
  );

  serial_mouse_report_checker u_check (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .op           (op),
    .host_byte    (host_byte),
    .host_x       (host_x),
    .host_y       (host_y),
    .button_index (button_index),
    .pressed      (pressed),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .reply_byte   (reply_byte),
    .ack          (ack),
    .errors       (errors),
    .pending      (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiving side. It stalls at random, and whenever a hold-off has been
  // asked for it stalls without a break for a long stretch, counted here, so
  // that the block fills up and has to stall its own input.
  initial begin
    int hold_left;
    int served;
    hold_left = 0;
    served    = 0;
    forever begin
      @(negedge clk);
      if (served != hold_requests) begin
        served    = hold_requests;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  // Watchdog: a run that hangs is a failed run.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Mismatches found");
    $finish;
  end

  function automatic smrr_pkg::item_t build_request(input logic [1:0] code,
                                                    input logic [7:0] din,
                                                    input logic signed [15:0] x,
                                                    input logic signed [15:0] y,
                                                    input logic [1:0] idx,
                                                    input logic pr);
    smrr_pkg::item_t r;
    r.op           = code;
    r.host_byte    = din;
    r.host_x       = x;
    r.host_y       = y;
    r.button_index = idx;
    r.pressed      = pr;
    return r;
  endfunction

  // A button event on any of the four indexes, with the unused fields noisy.
  function automatic smrr_pkg::item_t button_noise();
    return build_request(smrr_pkg::OP_BUTTON, 8'($urandom), 16'($urandom), 16'($urandom),
                         2'($urandom), 1'($urandom));
  endfunction

  // Offers one request and returns at the falling edge after it has been
  // taken. The valid stays high on return, so the next request can follow
  // back to back; whoever waits instead must lower it first.
  task automatic issue(input smrr_pkg::item_t r);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    op           <= r.op;
    host_byte    <= r.host_byte;
    host_x       <= r.host_x;
    host_y       <= r.host_y;
    button_index <= r.button_index;
    pressed      <= r.pressed;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    requests_sent++;
  endtask

  // Changes the idling of both sides on a rising edge, so that the receiver,
  // which reads these at the falling edge, never races the change.
  task automatic set_idling(input int send_gap, input int recv_gap, input bit hold);
    in_valid <= 1'b0;
    @(posedge clk);
    gap_pct   = send_gap;
    stall_pct = recv_gap;
    if (hold) hold_requests++;
    @(negedge clk);
  endtask

  // One transfer as the host would run it: poll, read command, then the
  // bytes that clock out the ID, the buttons and the two deltas. A cut short
  // of seven bytes leaves the sequencer part way through. With mixing on,
  // button events fall between the bytes now and then.
  task automatic poll_mouse(input logic signed [15:0] x, input logic signed [15:0] y,
                            input int cut, input bit mixed);
    logic [7:0] din;
    for (int b = 0; b < cut; b++) begin
      if (b == 0) din = smrr_pkg::CMD_POLL;
      else if (b == 1) din = smrr_pkg::CMD_READ;
      else din = 8'($urandom);
      issue(build_request(smrr_pkg::OP_BYTE, din, x, y, 2'($urandom), 1'($urandom)));
      if (mixed && $urandom_range(0, 4) == 0) issue(button_noise());
    end
  endtask

  // Mostly complete transfers with a moving pointer, the rest button events,
  // transfers broken off (often followed by a sequencer reset) and requests
  // that are random through and through.
  task automatic random_traffic(input int count);
    int stop_at;
    int kind;
    stop_at = requests_sent + count;
    while (requests_sent < stop_at) begin
      if ($urandom_range(0, 9) == 0) begin
        ptr_x = 16'($urandom);
        ptr_y = 16'($urandom);
      end else begin
        ptr_x = ptr_x + 16'($urandom_range(0, 400)) - 16'd200;
        ptr_y = ptr_y + 16'($urandom_range(0, 400)) - 16'd200;
      end
      kind = $urandom_range(0, 99);
      if (kind < 60) begin
        poll_mouse(ptr_x, ptr_y, 7, 1'b1);
      end else if (kind < 75) begin
        issue(button_noise());
      end else if (kind < 88) begin
        poll_mouse(ptr_x, ptr_y, $urandom_range(1, 6), 1'b1);
        if ($urandom_range(0, 1) == 1) begin
          issue(build_request(smrr_pkg::OP_RESET, 8'($urandom), 16'($urandom),
                              16'($urandom), 2'($urandom), 1'($urandom)));
        end
      end else begin
        issue(build_request(2'($urandom), 8'($urandom), 16'($urandom), 16'($urandom),
                            2'($urandom), 1'($urandom)));
      end
    end
  endtask

  initial begin
    repeat (3) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part. A stray byte while idle must be answered with the idle
    // byte and no acknowledge.
    issue(build_request(smrr_pkg::OP_BYTE, 8'h00, '0, '0, 2'd0, 1'b0));
    // Press both buttons, then try the two ignored indexes, which must leave
    // the button word alone.
    for (int i = 0; i < 4; i++) begin
      issue(build_request(smrr_pkg::OP_BUTTON, 8'hFF, '0, '0, 2'(i), 1'b1));
    end
    // A poll followed by a wrong command keeps the sequencer in Ready; the
    // read command then starts the ID, and a sequencer reset drops it again.
    issue(build_request(smrr_pkg::OP_BYTE, smrr_pkg::CMD_POLL, '0, '0, 2'd0, 1'b0));
    issue(build_request(smrr_pkg::OP_BYTE, 8'hFF, '0, '0, 2'd0, 1'b0));
    issue(build_request(smrr_pkg::OP_BYTE, smrr_pkg::CMD_READ, '0, '0, 2'd0, 1'b0));
    issue(build_request(smrr_pkg::OP_RESET, 8'hFF, 16'sh7FFF, 16'sh7FFF, 2'd3, 1'b1));
    // A full transfer with the pointer at the positive and negative extremes,
    // so that both deltas saturate.
    poll_mouse(16'sh7FFF, -16'sh8000, 7, 1'b0);
    // The unused op code must change nothing, even carrying a poll byte.
    issue(build_request(OP_SPARE, smrr_pkg::CMD_POLL, 16'shFFFF, 16'shFFFF, 2'd3, 1'b1));
    // Release both buttons and swing the pointer across the whole range.
    issue(build_request(smrr_pkg::OP_BUTTON, 8'h00, '0, '0, 2'd0, 1'b0));
    issue(build_request(smrr_pkg::OP_BUTTON, 8'h00, '0, '0, 2'd1, 1'b0));
    poll_mouse(-16'sh8000, 16'sh7FFF, 7, 1'b0);

    // Random part. The first phase opens with a long hold-off on the
    // receiving side while requests keep coming at full rate.
    set_idling(0, 0, 1'b1);
    random_traffic(400);
    set_idling(75, 0, 1'b0);
    random_traffic(400);
    set_idling(0, 75, 1'b0);
    random_traffic(400);
    set_idling(6, 6, 1'b0);
    random_traffic(425);

    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

>>> serial_mouse_report_responder.f
+incdir+hdl
hdl/smrr_pkg.sv
hdl/smrr_in_reg.sv
hdl/smrr_core.sv
hdl/smrr_out_reg.sv
hdl/serial_mouse_report_responder.sv
dv/serial_mouse_report_checker.sv
dv/serial_mouse_report_responder_test.sv
